>>> rtl/core/sfr_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the stuffed frame receiver
// no dependencies
package sfr_pkg;

  localparam logic [7:0] FRAME_BYTE_RST  = 8'h10;
  localparam logic [7:0] COUNT_MASK_RST  = 8'h0f;
  localparam int         NUM_OUT_BYTES   = 8;

  typedef enum logic [1:0] {
    CFG_FRAME_BYTE,
    CFG_STATION_ADDRS,
    CFG_COMMAND_CODES,
    CFG_COUNT_MASK
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]  frame_byte;
    logic [31:0] station_addrs;
    logic [31:0] command_codes;
    logic [7:0]  count_mask;
  } cfg_t;

  typedef struct packed {
    logic [7:0]                    address;
    logic [7:0]                    command;
    logic [3:0]                    length;
    logic [NUM_OUT_BYTES-1:0][7:0] data;
  } pkt_t;

  // byte matches one of four packed set entries
  function automatic logic in_set(input logic [31:0] set, input logic [7:0] b);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (set[8*k +: 8] == b) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

>>> rtl/core/sfr_deframer.sv
`timescale 1ns / 1ps
// frame hunt, address/command check, de-stuffing and xor checksum state machine
// depends on sfr_pkg
module sfr_deframer #(
  parameter int MAX_DATA = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  sfr_pkg::cfg_t cfg,
  input  logic          step,
  input  logic [7:0]    rx_byte,
  output logic          pkt_fire,
  output sfr_pkg::pkt_t pkt
);
  import sfr_pkg::*;

  localparam int FW = $clog2(MAX_DATA + 1);
  localparam int IW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;

  typedef enum logic [2:0] {
    PH_START,
    PH_ADDR,
    PH_CMD,
    PH_DATA,
    PH_CSUM
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic [7:0]    held_address_r, held_address_nxt;
  logic [7:0]    held_command_r, held_command_nxt;
  logic [FW-1:0] expected_count_r, expected_count_nxt;
  logic [FW-1:0] fill_index_r, fill_index_nxt;
  logic [7:0]    running_xor_r, running_xor_nxt;
  logic          stuff_watch_r, stuff_watch_nxt;
  logic [7:0]    last_byte_r, last_byte_nxt;
  logic [7:0]    payload_store [MAX_DATA];
  logic [7:0]    data_view [NUM_OUT_BYTES];
  logic          store_we;
  logic [7:0]    len_raw;
  logic          stuff_hit;
  logic          resync;

  assign len_raw   = rx_byte & cfg.count_mask;
  assign stuff_hit = stuff_watch_r && (fill_index_r != '0) && (last_byte_r == cfg.frame_byte);

  always_comb begin
    phase_nxt          = phase_r;
    held_address_nxt   = held_address_r;
    held_command_nxt   = held_command_r;
    expected_count_nxt = expected_count_r;
    fill_index_nxt     = fill_index_r;
    running_xor_nxt    = running_xor_r;
    stuff_watch_nxt    = stuff_watch_r;
    last_byte_nxt      = last_byte_r;
    store_we           = 1'b0;
    pkt_fire           = 1'b0;
    resync             = 1'b0;
    if (step) begin
      case (phase_r)
        PH_ADDR: begin
          if (in_set(cfg.station_addrs, rx_byte)) begin
            held_address_nxt = rx_byte;
            phase_nxt        = PH_CMD;
          end else if (rx_byte == cfg.frame_byte) begin
            phase_nxt = PH_ADDR;
          end else begin
            phase_nxt = PH_START;
          end
        end
        PH_CMD: begin
          if (in_set(cfg.command_codes, rx_byte)) begin
            held_command_nxt   = rx_byte;
            running_xor_nxt    = rx_byte;
            expected_count_nxt = (int'(len_raw) > MAX_DATA) ? FW'(MAX_DATA) : FW'(len_raw);
            fill_index_nxt     = '0;
            phase_nxt          = PH_DATA;
          end else if (rx_byte == cfg.frame_byte) begin
            phase_nxt = PH_ADDR;
          end else begin
            phase_nxt = PH_START;
          end
        end
        PH_DATA: begin
          if (stuff_hit) begin
            if (rx_byte == cfg.frame_byte) begin
              stuff_watch_nxt = 1'b0;
            end else begin
              // lone frame byte: this byte is a new address
              held_address_nxt = rx_byte;
              phase_nxt        = PH_CMD;
              resync           = 1'b1;
            end
          end else begin
            stuff_watch_nxt = 1'b1;
            if (int'(fill_index_r) < MAX_DATA) begin
              store_we       = 1'b1;
              fill_index_nxt = FW'(fill_index_r + 1'b1);
              last_byte_nxt  = rx_byte;
            end
            running_xor_nxt = running_xor_r ^ rx_byte;
          end
          if (!resync && (fill_index_nxt >= expected_count_r)) begin
            stuff_watch_nxt = 1'b1;
            phase_nxt       = PH_CSUM;
          end
        end
        PH_CSUM: begin
          if (stuff_watch_r && (rx_byte == cfg.frame_byte)) begin
            stuff_watch_nxt = 1'b0;
          end else begin
            phase_nxt = PH_START;
            pkt_fire  = (running_xor_r == rx_byte);
          end
        end
        default: begin
          if (rx_byte == cfg.frame_byte) phase_nxt = PH_ADDR;
          else                           phase_nxt = PH_START;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_START;
      held_address_r   <= '0;
      held_command_r   <= '0;
      expected_count_r <= '0;
      fill_index_r     <= '0;
      running_xor_r    <= '0;
      stuff_watch_r    <= 1'b1;
      last_byte_r      <= '0;
    end else begin
      phase_r          <= phase_nxt;
      held_address_r   <= held_address_nxt;
      held_command_r   <= held_command_nxt;
      expected_count_r <= expected_count_nxt;
      fill_index_r     <= fill_index_nxt;
      running_xor_r    <= running_xor_nxt;
      stuff_watch_r    <= stuff_watch_nxt;
      last_byte_r      <= last_byte_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) payload_store[fill_index_r[IW-1:0]] <= rx_byte;
  end

  // packet view
  always_comb begin
    pkt.address = held_address_r;
    pkt.command = held_command_r;
    if (int'(fill_index_r) > 15) pkt.length = 4'd15;
    else                         pkt.length = 4'(fill_index_r);
    for (int k = 0; k < NUM_OUT_BYTES; k++) pkt.data[k] = data_view[k];
  end

  for (genvar k = 0; k < NUM_OUT_BYTES; k++) begin : g_out
    if (k < MAX_DATA) begin : g_used
      assign data_view[k] = (fill_index_r > FW'(k)) ? payload_store[k] : 8'h00;
    end else begin : g_unused
      assign data_view[k] = 8'h00;
    end
  end

  a_fire_in_csum: assert property (@(posedge clk) disable iff (!rst_n)
    pkt_fire |-> step && (phase_r == PH_CSUM))
    else $error("packet emitted outside checksum phase");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (fill_index_r <= expected_count_r) &&
                             (int'(expected_count_r) <= MAX_DATA))
    else $error("fill index beyond expected count");

  a_cmd_start: assert property (@(posedge clk) disable iff (!rst_n)
    step && (phase_r == PH_CMD) && in_set(cfg.command_codes, rx_byte)
    |=> (phase_r == PH_DATA) && (fill_index_r == '0))
    else $error("accepted command did not open data phase");

  a_csum_from_data: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_CSUM) && !$past(phase_r == PH_CSUM) |-> stuff_watch_r &&
                                                          (fill_index_r >= expected_count_r))
    else $error("checksum phase entered early");

endmodule

>>> rtl/core/stuffed_frame_receiver.sv
`timescale 1ns / 1ps
// stuffed frame receiver top level: config registers, input beat register,
// deframer core and output packet register; depends on sfr_pkg, sfr_deframer
// out_valid is registered; the checksum beat goes through the input beat register first
// throughput: one received byte per cycle while no packet waits, set by the single-stage deframer
// the output register decouples; input is stalled only while a packet waits
// reset (rst_n, synchronous): config to defaults, hunting for a frame byte
module stuffed_frame_receiver #(
  parameter int MAX_DATA = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_pkt_address,
  output logic [7:0]  out_pkt_command,
  output logic [3:0]  out_pkt_length,
  output logic [7:0]  out_byte_0,
  output logic [7:0]  out_byte_1,
  output logic [7:0]  out_byte_2,
  output logic [7:0]  out_byte_3,
  output logic [7:0]  out_byte_4,
  output logic [7:0]  out_byte_5,
  output logic [7:0]  out_byte_6,
  output logic [7:0]  out_byte_7
);
  import sfr_pkg::*;

  cfg_t       cfg_r;
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       advance;
  logic       step;
  logic       pkt_fire;
  pkt_t       pkt;
  logic       out_valid_r;
  pkt_t       out_pkt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_byte    <= FRAME_BYTE_RST;
      cfg_r.station_addrs <= '0;
      cfg_r.command_codes <= '0;
      cfg_r.count_mask    <= COUNT_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_BYTE:    cfg_r.frame_byte    <= cfg_wdata[7:0];
        CFG_STATION_ADDRS: cfg_r.station_addrs <= cfg_wdata;
        CFG_COMMAND_CODES: cfg_r.command_codes <= cfg_wdata;
        CFG_COUNT_MASK:    cfg_r.count_mask    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign advance  = !out_valid_r || out_ready;
  assign step     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;

  // input beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_byte_r <= in_rx_byte;
  end

  sfr_deframer #(
    .MAX_DATA (MAX_DATA)
  ) u_deframer (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .step     (step),
    .rx_byte  (in_byte_r),
    .pkt_fire (pkt_fire),
    .pkt      (pkt)
  );

  // output packet register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step && pkt_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (step && pkt_fire) out_pkt_r <= pkt;
  end

  assign out_valid       = out_valid_r;
  assign out_pkt_address = out_pkt_r.address;
  assign out_pkt_command = out_pkt_r.command;
  assign out_pkt_length  = out_pkt_r.length;
  assign out_byte_0      = out_pkt_r.data[0];
  assign out_byte_1      = out_pkt_r.data[1];
  assign out_byte_2      = out_pkt_r.data[2];
  assign out_byte_3      = out_pkt_r.data[3];
  assign out_byte_4      = out_pkt_r.data[4];
  assign out_byte_5      = out_pkt_r.data[5];
  assign out_byte_6      = out_pkt_r.data[6];
  assign out_byte_7      = out_pkt_r.data[7];

endmodule
